### src/sfc_pkg.sv
// Shared types, constants and status codes of the sensor frame checker.
package sfc_pkg;

    // Frame limits and channel count.
    localparam int MAX_FRAME_BYTES = 32;
    localparam int CHANNELS        = 6;

    // Width of the byte position, which saturates at MAX_FRAME_BYTES + 1.
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Frame constants.
    localparam logic [7:0] MAGIC_BYTE   = 8'hA5;
    localparam logic [7:0] VERSION_BYTE = 8'h02;
    localparam logic [7:0] ANALOG_TYPE  = 8'h05;
    localparam logic [7:0] HEADER_EXTRA = 8'd5;
    localparam logic [7:0] ANALOG_LEN   = 8'd4;
    localparam int         HEAD_BYTES   = 4;

    // Percentage arithmetic.
    localparam int         RAW_W       = 16;
    localparam int         PCT_W       = 7;
    localparam int         NUM_W       = RAW_W + PCT_W;
    localparam int         DIV_W       = RAW_W + PCT_W - 1;
    localparam int         STEP_W      = $clog2(PCT_W);
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [RAW_W-1:0] FULL_SCALE_RESET = 16'd4095;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Result status codes.
    localparam logic [2:0] ST_DROP       = 3'd0;
    localparam logic [2:0] ST_BAD_FRAME  = 3'd1;
    localparam logic [2:0] ST_OTHER      = 3'd2;
    localparam logic [2:0] ST_BAD_ANALOG = 3'd3;
    localparam logic [2:0] ST_ANALOG     = 3'd4;

    // One received byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // One reported result.
    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       event_type;
        logic [7:0]       payload_length;
        logic [7:0]       channel;
        logic [7:0]       pin_number;
        logic [RAW_W-1:0] raw_value;
        logic [PCT_W-1:0] percent;
        logic [31:0]      invalid_total;
        logic [31:0]      unknown_total;
        logic [31:0]      drop_total;
    } t_out;

    // A classified frame waiting for the back end.
    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       event_type;
        logic [7:0]       payload_length;
        logic [7:0]       channel;
        logic [7:0]       pin_number;
        logic [RAW_W-1:0] raw_value;
        logic [31:0]      invalid_total;
        logic [31:0]      unknown_total;
        logic [31:0]      drop_total;
    } t_job;

    // Handshake between the queue and its neighbours.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

### src/sfc_front.sv
// Front end: takes frame bytes, tracks the frame and classifies it at the final byte.
module sfc_front
    import sfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in        i_in,
    output logic       o_in_stall,
    input  t_fifo_stat i_fifo_stat,
    output logic       o_push,
    output t_job       o_job
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_xor, n_xor;
    logic             r_hdr, n_hdr;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_head [HEAD_BYTES];
    logic [7:0]       n_head [HEAD_BYTES];
    logic [31:0]      r_inv, n_inv;
    logic [31:0]      r_unk, n_unk;
    logic [31:0]      r_drop, n_drop;
    logic [RAW_W-1:0] r_ch_value [CHANNELS];
    logic [7:0]       r_ch_pin [CHANNELS];
    logic [CHANNELS-1:0] r_ch_valid;

    logic             w_accept;
    logic [7:0]       w_frame_len;
    logic             w_store;
    t_job             w_job;

    // A request is taken whenever the queue has room.
    assign o_in_stall = i_fifo_stat.full;
    assign w_accept   = i_in_valid && !i_fifo_stat.full;

    // Frame tracking and classification of the frame that ends with this byte.
    always_comb begin
        n_pos  = r_pos;
        n_xor  = r_xor;
        n_hdr  = r_hdr;
        n_type = r_type;
        n_len  = r_len;
        n_head = r_head;
        n_inv  = r_inv;
        n_unk  = r_unk;
        n_drop = r_drop;
        w_store = 1'b0;

        if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            n_xor = r_xor ^ i_in.data_byte;
            if (r_pos == POS_W'(0) && i_in.data_byte != MAGIC_BYTE) begin
                n_hdr = 1'b0;
            end
            if (r_pos == POS_W'(1) && i_in.data_byte != VERSION_BYTE) begin
                n_hdr = 1'b0;
            end
            if (r_pos == POS_W'(2)) begin
                n_type = i_in.data_byte;
            end
            if (r_pos == POS_W'(3)) begin
                n_len = i_in.data_byte;
            end
            if (r_pos >= POS_W'(4) && r_pos < POS_W'(8)) begin
                n_head[r_pos[1:0]] = i_in.data_byte;
            end
        end
        if (r_pos <= POS_W'(MAX_FRAME_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
        end

        w_frame_len = 8'(r_pos) + 8'd1;
        w_job = '0;

        if (r_pos >= POS_W'(MAX_FRAME_BYTES)) begin
            n_drop = r_drop + 32'd1;
            w_job.status = ST_DROP;
        end else if (r_pos < POS_W'(4) || !n_hdr ||
                     w_frame_len != (n_len + HEADER_EXTRA) || n_xor != 8'd0) begin
            n_inv = r_inv + 32'd1;
            w_job.status = ST_BAD_FRAME;
        end else begin
            w_job.event_type     = n_type;
            w_job.payload_length = n_len;
            if (n_type != ANALOG_TYPE) begin
                n_unk = r_unk + 32'd1;
                w_job.status = ST_OTHER;
            end else if (n_len != ANALOG_LEN || n_head[0] >= 8'(CHANNELS)) begin
                n_inv = r_inv + 32'd1;
                w_job.status = ST_BAD_ANALOG;
            end else begin
                w_store = 1'b1;
                w_job.status     = ST_ANALOG;
                w_job.channel    = n_head[0];
                w_job.pin_number = n_head[1];
                w_job.raw_value  = {n_head[3], n_head[2]};
            end
        end
        w_job.invalid_total = n_inv;
        w_job.unknown_total = n_unk;
        w_job.drop_total    = n_drop;

        // The final byte restarts the frame.
        if (i_in.last_byte) begin
            n_pos = '0;
            n_xor = 8'd0;
            n_hdr = 1'b1;
        end
    end

    assign o_push = w_accept && i_in.last_byte;
    assign o_job  = w_job;

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_xor      <= 8'd0;
            r_hdr      <= 1'b1;
            r_type     <= 8'd0;
            r_len      <= 8'd0;
            r_inv      <= 32'd0;
            r_unk      <= 32'd0;
            r_drop     <= 32'd0;
            r_ch_valid <= '0;
        end else if (w_accept) begin
            r_pos  <= n_pos;
            r_xor  <= n_xor;
            r_hdr  <= n_hdr;
            r_type <= n_type;
            r_len  <= n_len;
            if (i_in.last_byte) begin
                r_inv  <= n_inv;
                r_unk  <= n_unk;
                r_drop <= n_drop;
                if (w_store) begin
                    r_ch_valid[n_head[0][CH_W-1:0]] <= 1'b1;
                end
            end
        end
    end

    // Payload head bytes are only read after being written in the same frame.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head <= n_head;
        end
    end

    // Per-channel readings, kept with their valid marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_ch_value[k] <= '0;
                r_ch_pin[k]   <= 8'd0;
            end
        end else if (w_accept && i_in.last_byte && w_store) begin
            r_ch_value[n_head[0][CH_W-1:0]] <= {n_head[3], n_head[2]};
            r_ch_pin[n_head[0][CH_W-1:0]]   <= n_head[1];
        end
    end

endmodule

### src/sfc_fifo.sv
// Short queue of classified frames between the front and back ends.
module sfc_fifo
    import sfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_job,
    output t_fifo_stat o_stat
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_job  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### src/sfc_back.sv
// Back end: computes the rounded percentage and holds the result register.
module sfc_back
    import sfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RAW_W-1:0] i_full_scale,
    input  t_fifo_stat       i_fifo_stat,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    output t_out             o_out,
    input  logic             i_out_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_LOAD
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [RAW_W-1:0]  r_full;
    logic [RAW_W-1:0]  r_clamp;
    logic [NUM_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [PCT_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_out              r_out;

    logic [RAW_W-1:0]  w_full;
    logic              w_fit;
    logic              w_out_free;

    // Full scale of zero counts as one.
    assign w_full = (i_full_scale == '0) ? RAW_W'(1) : i_full_scale;
    assign w_fit  = (r_rem >= NUM_W'(r_div));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop  = (r_state == S_IDLE) && !i_fifo_stat.empty;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Analog: multiply, seven restoring division steps, load; others only load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In the load state the result register is handled by the load itself.
            if (r_out_valid && !i_out_stall && r_state != S_LOAD) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_fifo_stat.empty) begin
                        r_job   <= i_job;
                        r_full  <= w_full;
                        r_clamp <= (i_job.raw_value > w_full) ? w_full : i_job.raw_value;
                        r_quo   <= '0;
                        r_state <= (i_job.status == ST_ANALOG) ? S_MUL : S_LOAD;
                    end
                end
                S_MUL: begin
                    r_rem   <= NUM_W'(r_clamp) * NUM_W'(PCT_SCALE) + NUM_W'(r_full >> 1);
                    r_div   <= DIV_W'(r_full) << (PCT_W - 1);
                    r_step  <= STEP_W'(PCT_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_fit) begin
                        r_rem <= r_rem - NUM_W'(r_div);
                    end
                    r_quo <= {r_quo[PCT_W-2:0], w_fit};
                    r_div <= r_div >> 1;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (w_out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.status         <= r_job.status;
                        r_out.event_type     <= r_job.event_type;
                        r_out.payload_length <= r_job.payload_length;
                        r_out.channel        <= r_job.channel;
                        r_out.pin_number     <= r_job.pin_number;
                        r_out.raw_value      <= r_job.raw_value;
                        r_out.percent        <= (r_job.status == ST_ANALOG) ? r_quo : '0;
                        r_out.invalid_total  <= r_job.invalid_total;
                        r_out.unknown_total  <= r_job.unknown_total;
                        r_out.drop_total     <= r_job.drop_total;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/sensor_frame_checker_unit.sv
// Top level of the sensor frame checker: front end, frame queue, back end and full-scale register.
//
// Frame bytes are taken one per clock while the two-entry frame queue has room; a byte that
// is not the last of its frame produces no result. At the final byte the frame is checked
// for size, header, declared length and XOR total, and its classification, counter totals
// and analog reading are queued. The back end then loads a frame without an analog update
// straight into the result register; for an analog update it first runs one multiply by one
// hundred and seven restoring division steps for the rounded percentage; either may wait
// on the output side. The result register lets the next frame be worked on while a result
// waits.
module sensor_frame_checker_unit
    import sfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in              i_in,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out             o_out,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    input  logic [RAW_W-1:0] i_cfg_data
);

    logic [RAW_W-1:0] r_full_scale;
    t_fifo_stat       w_fifo_stat;
    logic             w_push;
    logic             w_pop;
    t_job             w_push_job;
    t_job             w_head_job;

    // Full-scale configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FULL_SCALE_RESET;
        end else if (i_cfg_we) begin
            r_full_scale <= i_cfg_data;
        end
    end

    // Byte intake and classification.
    sfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_fifo_stat (w_fifo_stat),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // Queue of classified frames.
    sfc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_fifo_stat)
    );

    // Percentage and result delivery.
    sfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_full_scale (r_full_scale),
        .i_fifo_stat  (w_fifo_stat),
        .i_job        (w_head_job),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_stall  (i_out_stall)
    );

`ifndef NO_ASSERTIONS
    // A frame is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_fifo_stat.full))
        else $error("frame queue overflow");

    // The rounded percentage never exceeds one hundred.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_ANALOG) |-> (o_out.percent <= PCT_SCALE))
        else $error("percentage out of range");

    // Results without an analog update carry no reading.
    a_no_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_ANALOG) |->
        (o_out.raw_value == '0 && o_out.percent == '0))
        else $error("reading on a non-analog result");
`endif

endmodule
